[hw/rtl/psl_pkg.sv]
// Shared types, token codes and keyword table for the Pascal subset lexer.
package psl_pkg;

  localparam int LEN_WIDTH_DEF   = 16;
  localparam int POS_WIDTH_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int MAX_TOKENS      = 3;
  localparam int KW_COUNT        = 25;

  localparam logic [5:0] T_SEMI   = 6'd5;
  localparam logic [5:0] T_COMMA  = 6'd6;
  localparam logic [5:0] T_COLON  = 6'd7;
  localparam logic [5:0] T_LBRACK = 6'd16;
  localparam logic [5:0] T_RBRACK = 6'd17;
  localparam logic [5:0] T_LPAREN = 6'd20;
  localparam logic [5:0] T_RPAREN = 6'd21;
  localparam logic [5:0] T_ASSIGN = 6'd29;
  localparam logic [5:0] T_CMP    = 6'd35;
  localparam logic [5:0] T_MATH   = 6'd36;
  localparam logic [5:0] T_DOT    = 6'd37;
  localparam logic [5:0] T_IDENT  = 6'd38;
  localparam logic [5:0] T_NUMBER = 6'd39;
  localparam logic [5:0] T_STRING = 6'd40;
  localparam logic [5:0] T_ERROR  = 6'd41;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_type;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  token_type;
    logic [31:0] token_start;
    logic [15:0] token_length;
  } tok_t;

  // All tokens caused by one input item, oldest in slot 0.
  typedef struct packed {
    logic [1:0]            cnt;
    tok_t [MAX_TOKENS-1:0] recs;
  } bundle_t;

  // Keywords are left-justified, first character in the top byte.
  localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
    {"begin", 32'd0}, {"end", 48'd0}, {"const", 32'd0}, {"type", 40'd0},
    {"var", 48'd0}, {"integer", 16'd0}, {"real", 40'd0}, {"char", 40'd0},
    {"boolean", 16'd0}, {"array", 32'd0}, {"record", 24'd0}, {"of", 56'd0},
    {"function", 8'd0}, "procedure", {"while", 32'd0},
    {"do", 56'd0}, {"if", 56'd0}, {"then", 40'd0}, {"for", 48'd0},
    {"write", 32'd0}, {"read", 40'd0}, {"to", 56'd0}, {"else", 40'd0},
    {"false", 32'd0}, {"true", 40'd0}
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd3, 4'd5, 4'd4, 4'd3, 4'd7, 4'd4, 4'd4, 4'd7, 4'd5, 4'd6, 4'd2,
    4'd8, 4'd9, 4'd5, 4'd2, 4'd2, 4'd4, 4'd3, 4'd5, 4'd4, 4'd2, 4'd4, 4'd5, 4'd4
  };
  localparam logic [5:0] KW_CODE [KW_COUNT] = '{
    6'd0, 6'd1, 6'd2, 6'd3, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
    6'd18, 6'd19, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd30, 6'd31,
    6'd32, 6'd33
  };

  // Bytes past the identifier's length are zero, so a full compare is exact.
  function automatic logic [5:0] kw_lookup(input logic [71:0] pre, input logic [3:0] len);
    logic [5:0] code;
    code = T_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (len == KW_LEN[i] && pre == KW_TEXT[i]) code = KW_CODE[i];
    end
    return code;
  endfunction

endpackage

[hw/rtl/pascal_subset_lexer.sv]
// Top level of the Pascal subset lexer: front end feeding the result queue.
//
// Input channel: one source byte per item with an end-of-source flag. An item
// is accepted when in_push is high and in_full is low; the block takes one
// item per cycle while the result queue has room.
// Result channel: token records in source order. While out_empty is low the
// oldest record is on out_item; out_pop takes it. last_of_run marks the final
// record caused by one input byte.
// Records caused by a byte enter the bundle queue when the byte is accepted
// and reach out_item once older records are taken. Throughput: one byte per
// cycle in while the queue has room, one record per cycle out while out_pop
// is high; a byte makes zero to two records, each taken by its own pop. The
// front end classifies the byte combinationally against its state registers
// and the keyword table; a QUEUE_DEPTH-entry bundle queue separates it from
// the output side. When the receiver stalls, the queue fills and in_full
// rises; no record is lost. Reset (rst_n low, synchronous) empties the queue
// and returns the lexer to idle with position zero.
module pascal_subset_lexer import psl_pkg::*; #(
  parameter int LEN_WIDTH   = LEN_WIDTH_DEF,
  parameter int POS_WIDTH   = POS_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  bundle_t bundle;
  logic    accept;

  assign accept = in_push && !in_full;

  psl_front #(.LEN_WIDTH(LEN_WIDTH), .POS_WIDTH(POS_WIDTH)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .bundle (bundle)
  );

  psl_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (accept),
    .bundle (bundle),
    .full   (in_full),
    .empty  (out_empty),
    .pop    (out_pop),
    .item   (out_item)
  );

endmodule

[hw/rtl/psl_front.sv]
// Lexer front end: classifies one byte per item and builds its token bundle.
module psl_front import psl_pkg::*; #(
  parameter int LEN_WIDTH = LEN_WIDTH_DEF,
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output bundle_t  bundle
);

  typedef enum logic [4:0] {
    M_IDLE   = 5'b00001,
    M_IDENT  = 5'b00010,
    M_NUMBER = 5'b00100,
    M_STRING = 5'b01000,
    M_PENDOP = 5'b10000
  } mode_t;

  mode_t                mode_r, mode_nxt;
  logic [0:8][7:0]      pre_r, pre_nxt;
  logic [LEN_WIDTH-1:0] len_r, len_nxt;
  logic [POS_WIDTH-1:0] start_r, start_nxt;
  logic [POS_WIDTH-1:0] pos_r;
  logic                 dot_r, dot_nxt;
  logic [7:0]           pend_r, pend_nxt;

  function automatic tok_t mk(input logic [5:0] t, input logic [POS_WIDTH-1:0] s,
                              input logic [LEN_WIDTH-1:0] l);
    tok_t        r;
    logic [63:0] s64;
    logic [63:0] l64;
    s64 = 64'(s);
    l64 = 64'(l);
    r.token_type   = t;
    r.token_start  = s64[31:0];
    r.token_length = l64[15:0];
    return r;
  endfunction

  logic [7:0]           c;
  logic                 is_letter, is_digit, is_space, is_quote;
  logic                 fresh;
  logic [1:0]           n;
  tok_t [MAX_TOKENS-1:0] recs;
  logic [5:0]           t1;
  logic [LEN_WIDTH-1:0] one_len, two_len;

  assign c         = item.char_code;
  assign is_letter = (c inside {[8'h61:8'h7a], [8'h41:8'h5a]});
  assign is_digit  = (c inside {[8'h30:8'h39]});
  assign is_space  = (c == 8'h20) || (c inside {[8'd9:8'd13]});
  assign is_quote  = (c == 8'h27) || (c == 8'h22);
  assign one_len   = LEN_WIDTH'(1);
  assign two_len   = LEN_WIDTH'(2);

  always_comb begin
    mode_nxt  = mode_r;
    pre_nxt   = pre_r;
    len_nxt   = len_r;
    start_nxt = start_r;
    dot_nxt   = dot_r;
    pend_nxt  = pend_r;
    n         = 2'd0;
    recs      = '0;
    fresh     = 1'b0;
    t1        = T_ERROR;

    case (mode_r)
      M_PENDOP: begin
        if (c == "=") begin
          recs[n] = mk((pend_r == ":") ? T_ASSIGN : T_CMP, start_r, two_len);
          n = n + 2'd1;
          mode_nxt = M_IDLE;
          pend_nxt = '0;
        end else begin
          recs[n] = mk((pend_r == ":") ? T_COLON :
                       ((pend_r == "<" || pend_r == ">" || pend_r == "=") ? T_CMP : T_ERROR),
                       start_r, one_len);
          n = n + 2'd1;
          mode_nxt = M_IDLE;
          dot_nxt  = 1'b0;
          pend_nxt = '0;
          fresh    = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_letter || is_digit) begin
          if (len_r < LEN_WIDTH'(9)) pre_nxt[len_r[3:0]] = c;
          if (len_r != '1) len_nxt = len_r + one_len;
        end else begin
          recs[n] = mk((len_r > LEN_WIDTH'(9)) ? T_IDENT : kw_lookup(pre_r, len_r[3:0]),
                       start_r, len_r);
          n = n + 2'd1;
          mode_nxt = M_IDLE;
          dot_nxt  = 1'b0;
          pend_nxt = '0;
          fresh    = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit) begin
          if (len_r != '1) len_nxt = len_r + one_len;
        end else if (c == ".") begin
          if (!dot_r) begin
            if (len_r != '1) len_nxt = len_r + one_len;
            dot_nxt = 1'b1;
          end else begin
            // Second dot: number so far is an error, the dot is a period.
            recs[n] = mk(T_ERROR, start_r, len_r);
            n = n + 2'd1;
            recs[n] = mk(T_DOT, pos_r, one_len);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
            dot_nxt  = 1'b0;
          end
        end else begin
          recs[n] = mk(T_NUMBER, start_r, len_r);
          n = n + 2'd1;
          mode_nxt = M_IDLE;
          dot_nxt  = 1'b0;
          pend_nxt = '0;
          fresh    = 1'b1;
        end
      end
      M_STRING: begin
        if (len_r != '1) len_nxt = len_r + one_len;
        if (is_quote) begin
          recs[n] = mk(T_STRING, start_r, len_nxt);
          n = n + 2'd1;
          mode_nxt = M_IDLE;
        end
      end
      default: begin
        mode_nxt = M_IDLE;
        fresh    = 1'b1;
      end
    endcase

    if (fresh && !is_space) begin
      if (is_letter || is_digit || is_quote ||
          c == ":" || c == "<" || c == ">" || c == "!" || c == "=") begin
        start_nxt = pos_r;
        len_nxt   = one_len;
        dot_nxt   = 1'b0;
        if (is_letter) begin
          mode_nxt   = M_IDENT;
          pre_nxt    = '0;
          pre_nxt[0] = c;
        end else if (is_digit) begin
          mode_nxt = M_NUMBER;
        end else if (is_quote) begin
          mode_nxt = M_STRING;
        end else begin
          mode_nxt = M_PENDOP;
          pend_nxt = c;
        end
      end else begin
        case (c)
          ";":     t1 = T_SEMI;
          ",":     t1 = T_COMMA;
          "(":     t1 = T_LPAREN;
          ")":     t1 = T_RPAREN;
          "[":     t1 = T_LBRACK;
          "]":     t1 = T_RBRACK;
          ".":     t1 = T_DOT;
          "+", "-", "*", "/": t1 = T_MATH;
          default: t1 = T_ERROR;
        endcase
        recs[n] = mk(t1, pos_r, one_len);
        n = n + 2'd1;
      end
    end

    if (item.end_of_source) begin
      case (mode_nxt)
        M_IDENT: begin
          recs[n] = mk((len_nxt > LEN_WIDTH'(9)) ? T_IDENT :
                       kw_lookup(pre_nxt, len_nxt[3:0]), start_nxt, len_nxt);
          n = n + 2'd1;
        end
        M_NUMBER: begin
          recs[n] = mk(T_NUMBER, start_nxt, len_nxt);
          n = n + 2'd1;
        end
        M_STRING: begin
          recs[n] = mk(T_STRING, start_nxt, len_nxt);
          n = n + 2'd1;
        end
        M_PENDOP: begin
          recs[n] = mk((pend_nxt == ":") ? T_COLON :
                       ((pend_nxt == "<" || pend_nxt == ">" || pend_nxt == "=") ?
                        T_CMP : T_ERROR), start_nxt, one_len);
          n = n + 2'd1;
        end
        default: ;
      endcase
      mode_nxt = M_IDLE;
      dot_nxt  = 1'b0;
      pend_nxt = '0;
    end

    bundle.cnt  = n;
    bundle.recs = recs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pre_r   <= '0;
      len_r   <= '0;
      start_r <= '0;
      pos_r   <= '0;
      dot_r   <= 1'b0;
      pend_r  <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pre_r   <= pre_nxt;
      len_r   <= len_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_r + POS_WIDTH'(1);
      dot_r   <= dot_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

[hw/rtl/psl_back.sv]
// Lexer back end: bundle queue and one-token-per-cycle result delivery while pop is high.
module psl_back import psl_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  bundle_t   bundle,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_item_t item
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bundle_t       mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    slot_r;
  bundle_t       head;
  logic          do_push, do_pop, last;

  assign full    = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rp_r];
  assign last    = (slot_r == head.cnt - 2'd1);
  assign do_push = push && (bundle.cnt != 2'd0);
  assign do_pop  = pop && !empty && last;

  assign item.token_type   = head.recs[slot_r].token_type;
  assign item.token_start  = head.recs[slot_r].token_start;
  assign item.token_length = head.recs[slot_r].token_length;
  assign item.last_of_run  = last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      slot_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (pop && !empty) begin
        if (last) begin
          slot_r <= '0;
          rp_r   <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PW'(1);
        end else begin
          slot_r <= slot_r + 2'd1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH)) else $error("queue count beyond depth");
  a_slot_in_head: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (slot_r < head.cnt)) else $error("slot beyond head bundle");
  a_slot_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> (slot_r == 2'd0)) else $error("slot not cleared on empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !do_pop) |=> (wp_r == $past(wp_r))) else $error("write while full");
`endif

endmodule
